@@ rtl/sre_pkg.sv @@
// ----------------------------------------------------------------------------
// sre_pkg
// Shared types and constants of the space run entab block.
// ----------------------------------------------------------------------------
package sre_pkg;

	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] CH_NEWLINE = 8'd10;

	localparam logic [5:0]  TAB_SIZE_RESET = 6'd8;
	localparam logic [5:0]  TAB_SIZE_MIN   = 6'd4;
	localparam logic [5:0]  TAB_SIZE_MAX   = 6'd32;
	localparam logic [15:0] TAB_COUNT_MAX  = 16'hFFFF;

	// fixed-width part of a queued command; column fields travel beside it
	typedef struct packed {
		logic [7:0] ch;
		logic       pending;
		logic       ovf;
		logic [5:0] ts;
	} sre_head_t;

endpackage

@@ rtl/sre_in_if.sv @@
// ----------------------------------------------------------------------------
// sre_in_if
// Character input channel: valid/ready handshake with one byte payload.
// ----------------------------------------------------------------------------
interface sre_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;

	modport source (output valid, output in_char, input ready);
	modport sink (input valid, input in_char, output ready);
endinterface

@@ rtl/sre_out_if.sv @@
// ----------------------------------------------------------------------------
// sre_out_if
// Result channel: valid/ready handshake with output byte and status fields.
// ----------------------------------------------------------------------------
interface sre_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_char;
	logic        last_of_run;
	logic [15:0] tabs_made;
	logic        column_overflow;

	modport source (output valid, output out_char, output last_of_run,
		output tabs_made, output column_overflow, input ready);
	modport sink (input valid, input out_char, input last_of_run,
		input tabs_made, input column_overflow, output ready);
endinterface

@@ rtl/space_run_entab.sv @@
// ----------------------------------------------------------------------------
// space_run_entab
// Converts runs of spaces in a character stream into tabs and spaces.
//
//   port      dir  transfer payload
//   chars     in   in_char
//   results   out  out_char, last_of_run, tabs_made, column_overflow
//   cfg_*     in   tab_size write, no handshake
//
// the front takes one character per cycle while the command queue has room;
// spaces only update front state and are not queued
// the back pops a command only while idle and finishes it before the next;
// a run of one space goes straight to its space, a longer run first takes
// remainder steps one bit at a time, then emits tabs, spaces and the char
// reset clears all control state and sets the tab size to 8
// a stalled result channel fills the queue and then holds off chars.ready
// ----------------------------------------------------------------------------
module space_run_entab #(
	parameter int LINE_COLUMNS = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata,
	sre_in_if.sink     chars,
	sre_out_if.source  results
);
	import sre_pkg::*;

	localparam int CW = $clog2(LINE_COLUMNS);
	localparam int HW = $bits(sre_head_t);
	localparam int QW = HW + 2 * CW;

	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_empty;
	sre_head_t     f_head;
	logic [CW-1:0] f_run_start;
	logic [CW-1:0] f_column;
	logic [QW-1:0] q_rd_data;
	sre_head_t     b_head;
	logic [CW-1:0] b_run_start;
	logic [CW-1:0] b_column;

	assign {b_head, b_run_start, b_column} = q_rd_data;

	sre_front #(
		.LINE_COLUMNS(LINE_COLUMNS),
		.CW(CW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.chars(chars),
		.q_full(q_full),
		.q_push(q_push),
		.q_head(f_head),
		.q_run_start(f_run_start),
		.q_column(f_column)
	);

	sre_queue #(
		.DATA_W(QW),
		.DEPTH(4)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data({f_head, f_run_start, f_column}),
		.full(q_full),
		.pop(q_pop),
		.pop_data(q_rd_data),
		.empty(q_empty)
	);

	sre_back #(
		.LINE_COLUMNS(LINE_COLUMNS),
		.CW(CW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.q_head(b_head),
		.q_run_start(b_run_start),
		.q_column(b_column),
		.results(results)
	);

endmodule

@@ rtl/sre_front.sv @@
// ----------------------------------------------------------------------------
// sre_front
// Accepts characters, tracks column and pending space run, queues commands.
// ----------------------------------------------------------------------------
module sre_front #(
	parameter int LINE_COLUMNS = 128,
	parameter int CW = $clog2(LINE_COLUMNS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [5:0]          cfg_wdata,
	sre_in_if.sink              chars,
	input  logic                q_full,
	output logic                q_push,
	output sre_pkg::sre_head_t  q_head,
	output logic [CW-1:0]       q_run_start,
	output logic [CW-1:0]       q_column
);
	import sre_pkg::*;

	localparam logic [CW-1:0] MAX_COL = CW'(LINE_COLUMNS - 1);

	logic [5:0]    tab_size_q;
	logic [5:0]    eff_ts;
	logic [CW-1:0] column_q;
	logic [CW-1:0] run_start_q;
	logic          pending_q;
	logic          ovf_q;
	logic          accept;
	logic          is_space;
	logic          is_nl;
	logic          at_bound;
	logic          ovf_new;

	assign chars.ready = !q_full;
	assign accept      = chars.valid && chars.ready;
	assign is_space    = (chars.in_char == CH_SPACE);
	assign is_nl       = (chars.in_char == CH_NEWLINE);
	assign at_bound    = (column_q >= MAX_COL);
	assign ovf_new     = is_nl ? ovf_q : (ovf_q | at_bound);

	always_comb begin
		if (tab_size_q < TAB_SIZE_MIN) begin
			eff_ts = TAB_SIZE_MIN;
		end else if (tab_size_q > TAB_SIZE_MAX) begin
			eff_ts = TAB_SIZE_MAX;
		end else begin
			eff_ts = tab_size_q;
		end
	end

	assign q_push         = accept && !is_space;
	assign q_head.ch      = chars.in_char;
	assign q_head.pending = pending_q;
	assign q_head.ovf     = ovf_new;
	assign q_head.ts      = eff_ts;
	assign q_run_start    = run_start_q;
	assign q_column       = column_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_size_q  <= TAB_SIZE_RESET;
			column_q    <= '0;
			run_start_q <= '0;
			pending_q   <= 1'b0;
			ovf_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				tab_size_q <= cfg_wdata;
			end
			if (accept) begin
				if (is_space) begin
					if (!at_bound) begin
						if (!pending_q) begin
							run_start_q <= column_q;
							pending_q   <= 1'b1;
						end
						column_q <= column_q + 1'b1;
					end else begin
						ovf_q <= 1'b1;
					end
				end else begin
					pending_q <= 1'b0;
					if (is_nl) begin
						column_q <= '0;
						ovf_q    <= 1'b0;
					end else begin
						ovf_q <= ovf_new;
						if (!at_bound) begin
							column_q <= column_q + 1'b1;
						end
					end
				end
			end
		end
	end

endmodule

@@ rtl/sre_queue.sv @@
// ----------------------------------------------------------------------------
// sre_queue
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
module sre_queue #(
	parameter int DATA_W = 32,
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output logic              empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [AW:0]       count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == (AW+1)'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/sre_back.sv @@
// ----------------------------------------------------------------------------
// sre_back
// Expands queued commands into tabs, spaces and the passed character.
// ----------------------------------------------------------------------------
module sre_back #(
	parameter int LINE_COLUMNS = 128,
	parameter int CW = $clog2(LINE_COLUMNS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	output logic                q_pop,
	input  sre_pkg::sre_head_t  q_head,
	input  logic [CW-1:0]       q_run_start,
	input  logic [CW-1:0]       q_column,
	sre_out_if.source           results
);
	import sre_pkg::*;

	localparam int SW = CW + 1;
	localparam int BW = $clog2(CW);

	typedef enum logic [2:0] {
		B_IDLE,
		B_DIV,
		B_TAB,
		B_SPC,
		B_CHR
	} state_t;

	state_t        state_q;
	logic [7:0]    ch_q;
	logic          ovf_q;
	logic [5:0]    ts_q;
	logic [CW-1:0] col_q;
	logic [CW-1:0] sp_q;
	logic [SW-1:0] stop_q;
	logic [5:0]    rem_q;
	logic [BW-1:0] bit_q;
	logic [15:0]   tab_total_q;
	logic          out_v_q;
	logic [7:0]    out_char_q;
	logic          out_last_q;
	logic [15:0]   out_tabs_q;
	logic          out_ovf_q;

	logic          slot;
	logic          emit;
	logic [7:0]    e_char;
	logic          e_last;
	logic [15:0]   e_tabs;
	logic [15:0]   tab_inc;
	logic [6:0]    rem_try;
	logic [5:0]    rem_nxt;
	logic          tab_due;
	logic          spc_due;

	assign slot    = !out_v_q || results.ready;
	assign tab_inc = (tab_total_q == TAB_COUNT_MAX) ? tab_total_q : tab_total_q + 1'b1;
	assign tab_due = (stop_q <= {1'b0, col_q});
	assign spc_due = (sp_q < col_q);
	assign q_pop   = (state_q == B_IDLE) && !q_empty;

	// one bit of restoring remainder per cycle
	assign rem_try = {rem_q, sp_q[bit_q]};
	assign rem_nxt = (rem_try >= {1'b0, ts_q}) ? 6'(rem_try - {1'b0, ts_q}) : rem_try[5:0];

	always_comb begin
		emit   = 1'b0;
		e_char = ch_q;
		e_last = 1'b0;
		e_tabs = tab_total_q;
		unique case (state_q)
			B_TAB: begin
				if (slot && tab_due) begin
					emit   = 1'b1;
					e_char = CH_TAB;
					e_tabs = tab_inc;
				end
			end
			B_SPC: begin
				if (slot && spc_due) begin
					emit   = 1'b1;
					e_char = CH_SPACE;
				end
			end
			B_CHR: begin
				if (slot) begin
					emit   = 1'b1;
					e_last = 1'b1;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign results.valid           = out_v_q;
	assign results.out_char        = out_char_q;
	assign results.last_of_run     = out_last_q;
	assign results.tabs_made       = out_tabs_q;
	assign results.column_overflow = out_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			ch_q        <= '0;
			ovf_q       <= 1'b0;
			ts_q        <= TAB_SIZE_RESET;
			col_q       <= '0;
			sp_q        <= '0;
			stop_q      <= '0;
			rem_q       <= '0;
			bit_q       <= '0;
			tab_total_q <= '0;
			out_v_q     <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
			out_tabs_q  <= '0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (emit) begin
				out_v_q    <= 1'b1;
				out_char_q <= e_char;
				out_last_q <= e_last;
				out_tabs_q <= e_tabs;
				out_ovf_q  <= ovf_q;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						ch_q  <= q_head.ch;
						ovf_q <= q_head.ovf;
						ts_q  <= q_head.ts;
						col_q <= q_column;
						sp_q  <= q_run_start;
						if (!q_head.pending) begin
							state_q <= B_CHR;
						end else if ({1'b0, q_run_start} + 1'b1 == {1'b0, q_column}) begin
							state_q <= B_SPC;
						end else begin
							rem_q   <= '0;
							bit_q   <= BW'(CW - 1);
							state_q <= B_DIV;
						end
					end
				end
				B_DIV: begin
					rem_q <= rem_nxt;
					if (bit_q == '0) begin
						stop_q  <= SW'(sp_q) + SW'(ts_q - rem_nxt);
						state_q <= B_TAB;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				B_TAB: begin
					if (tab_due) begin
						if (slot) begin
							tab_total_q <= tab_inc;
							sp_q        <= stop_q[CW-1:0];
							stop_q      <= stop_q + SW'(ts_q);
						end
					end else begin
						state_q <= B_SPC;
					end
				end
				B_SPC: begin
					if (spc_due) begin
						if (slot) begin
							sp_q <= sp_q + 1'b1;
						end
					end else begin
						state_q <= B_CHR;
					end
				end
				B_CHR: begin
					if (slot) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule
